/* sv/ocbr_pkg.sv */
package ocbr_pkg;

    // Default depth of the log2 fraction table (power of two)
    localparam int unsigned DEF_LOG_TABLE_ENTRIES = 256;

    // Square-root chain of the exponent unit: one stage per fraction bit
    localparam int unsigned ROOT_STEPS = 30;

    // Register stages in front of the exponent unit
    localparam int unsigned FRONT_STAGES = 23;

    // Fixed-point constants
    localparam logic signed [31:0] RAD_LIMIT      = 32'sd1310720;
    localparam logic [31:0]        LOG10_OF_2_Q32 = 32'd1292913986;
    localparam logic [31:0]        LOG2_OF_10_Q30 = 32'd3566893132;

    // Result status codes
    localparam logic [2:0] STATUS_VALID        = 3'd0;
    localparam logic [2:0] STATUS_NOT_POSITIVE = 3'd1;
    localparam logic [2:0] STATUS_RATIO_LOW    = 3'd2;
    localparam logic [2:0] STATUS_SATURATED    = 3'd3;
    localparam logic [2:0] STATUS_NEGATIVE     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_IRR_BLUE    = 3'd0;
    localparam logic [2:0] REG_IRR_MID     = 3'd1;
    localparam logic [2:0] REG_IRR_GREEN   = 3'd2;
    localparam logic [2:0] REG_COEFF_ZERO  = 3'd3;
    localparam logic [2:0] REG_COEFF_ONE   = 3'd4;
    localparam logic [2:0] REG_COEFF_TWO   = 3'd5;
    localparam logic [2:0] REG_COEFF_THREE = 3'd6;
    localparam logic [2:0] REG_COEFF_FOUR  = 3'd7;

    // Side band carried down the exponent chain
    typedef struct packed {
        logic [4:0] n;
        logic       force_sat;
        logic       force_zero;
        logic [2:0] status;
    } ocbr_side_t;

    // log2(1 + idx/2^lg2n) in Q2.30, by repeated squaring
    function automatic logic [31:0] log_entry(input int unsigned idx, input int unsigned lg2n);
        logic [63:0] z;
        logic [31:0] acc;
        z   = (64'(idx) + (64'd1 << lg2n)) << (30 - lg2n);
        acc = '0;
        if (idx >= (32'd1 << lg2n)) begin
            acc = 32'h4000_0000;
        end else begin
            for (int k = 29; k >= 0; k--) begin
                z = (z * z) >> 30;
                if (z >= (64'd1 << 31)) begin
                    z      = z >> 1;
                    acc[k] = 1'b1;
                end
            end
        end
        return acc;
    endfunction

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int q = 0; q < 32; q++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int q = 0; q < 32; q++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(2^-(idx+1)) in Q2.30 by repeated square roots of two
    function automatic logic [31:0] root_entry(input int unsigned idx);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int unsigned k = 0; k <= idx; k++) begin
            r = isqrt64(r << 30);
        end
        return r[31:0];
    endfunction

endpackage

/* sv/ocbr_log2.sv */
module ocbr_log2
    import ocbr_pkg::*;
#(
    parameter int unsigned LOG_TABLE_ENTRIES = DEF_LOG_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] x,
    output logic [35:0] y
);

    localparam int unsigned TAB_BITS = $clog2(LOG_TABLE_ENTRIES);

    // Fraction table, one more entry for the top of the interval
    logic [31:0] log_tab [LOG_TABLE_ENTRIES + 1];

    for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
        assign log_tab[g] = log_entry(g, TAB_BITS);
    end

    logic [4:0]  lead;
    logic [63:0] norm;
    logic [4:0]  e0_reg;
    logic [31:0] f0_reg;
    logic [TAB_BITS-1:0] idx;
    logic [4:0]  e1_reg;
    logic [31:0] lo1_reg;
    logic [31:0] hi1_reg;
    logic [31:0] w1_reg;
    logic [63:0] prod_next;
    logic [4:0]  e2_reg;
    logic [31:0] lo2_reg;
    logic [31:0] frac2_reg;
    logic [35:0] y_reg;

    // Find the leading one
    always_comb begin
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                lead = 5'(i);
            end
        end
    end

    // Normalise below the leading one
    assign norm = {32'd0, x} << (6'd32 - {1'b0, lead});

    assign idx       = f0_reg[31 -: TAB_BITS];
    assign prod_next = 64'(hi1_reg - lo1_reg) * 64'(w1_reg);

    // Four stages: normalise, look up, interpolate, add exponent
    always_ff @(posedge aclk) begin
        if (adv) begin
            e0_reg    <= lead;
            f0_reg    <= norm[31:0];
            e1_reg    <= e0_reg;
            lo1_reg   <= log_tab[{1'b0, idx}];
            hi1_reg   <= log_tab[{1'b0, idx} + (TAB_BITS + 1)'(1)];
            w1_reg    <= f0_reg << TAB_BITS;
            e2_reg    <= e1_reg;
            lo2_reg   <= lo1_reg;
            frac2_reg <= prod_next[63:32];
            y_reg     <= {1'b0, e2_reg, 30'd0} + 36'(lo2_reg) + 36'(frac2_reg);
        end
    end

    assign y = y_reg;

endmodule

/* sv/ocbr_exp2.sv */
module ocbr_exp2
    import ocbr_pkg::*;
(
    input  logic        aclk,
    input  logic        adv,
    input  logic [29:0] f_in,
    input  ocbr_side_t  side_in,
    output logic [31:0] mm_out,
    output ocbr_side_t  side_out
);

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    logic [31:0] root_tab [ROOT_STEPS];
    logic [31:0] mm_in    [ROOT_STEPS];
    logic [29:0] f_arr    [ROOT_STEPS];
    ocbr_side_t  side_arr [ROOT_STEPS];
    logic [63:0] prod     [ROOT_STEPS];
    logic [31:0] mm_reg   [ROOT_STEPS];
    logic [29:0] f_reg    [ROOT_STEPS];
    ocbr_side_t  side_reg [ROOT_STEPS];

    // Chain the stage inputs
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
        assign root_tab[j] = root_entry(j);
        if (j == 0) begin : g_first
            assign mm_in[j]    = ONE_Q30;
            assign f_arr[j]    = f_in;
            assign side_arr[j] = side_in;
        end else begin : g_next
            assign mm_in[j]    = mm_reg[j-1];
            assign f_arr[j]    = f_reg[j-1];
            assign side_arr[j] = side_reg[j-1];
        end
        assign prod[j] = 64'(mm_in[j]) * 64'(root_tab[j]);
    end

    // Multiply in one root per set fraction bit, one bit a stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < ROOT_STEPS; j++) begin
                mm_reg[j]   <= f_arr[j][ROOT_STEPS-1-j] ? prod[j][61:30] : mm_in[j];
                f_reg[j]    <= f_arr[j];
                side_reg[j] <= side_arr[j];
            end
        end
    end

    assign mm_out   = mm_reg[ROOT_STEPS-1];
    assign side_out = side_reg[ROOT_STEPS-1];

endmodule

/* sv/ocean_chlorophyll_band_ratio.sv */
// Channel  Dir  Handshake         Payload
// s_       in   s_valid/s_ready   radiance_blue, radiance_mid, radiance_green (Q16.16 s)
// m_       out  m_valid/m_ready   chlorophyll (Q10.22 u), status
// cfg_     in   cfg_we            cfg_index, cfg_data
//
// One pixel word is taken every cycle while s_ready is high; its result word passes
// through nine ratio and log stages, four Horner steps of three stages each, two range
// stages and the thirty-stage root product chain of the exponent unit, then the output
// word register, and then appears on m_.
// Reset clears the pipeline valid bits and the output and skid valid flags and loads
// the default irradiances and coefficients. A stalled output word parks in one skid
// word; the whole pipeline holds only while that skid word is full.
module ocean_chlorophyll_band_ratio
    import ocbr_pkg::*;
#(
    parameter int unsigned LOG_TABLE_ENTRIES = DEF_LOG_TABLE_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_radiance_blue,
    input  logic signed [31:0] s_radiance_mid,
    input  logic signed [31:0] s_radiance_green,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_chlorophyll,
    output logic [2:0]         m_status
);

    localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + ROOT_STEPS;
    localparam int unsigned HORNER_STEPS = 4;
    localparam int unsigned STAT_FIRST   = 5;
    localparam int unsigned STAT_LAST    = 21;
    localparam logic signed [58:0] HORNER_LIMIT = 59'sd281474976710656;
    localparam logic signed [49:0] P_SAT_LIMIT  = 50'sd1073741824;
    localparam logic signed [49:0] P_ZERO_LIMIT = -50'sd2147483648;
    localparam logic signed [37:0] W_OFFSET     = 38'sd23622320128;
    localparam logic signed [37:0] W_TOP        = 38'sd34359738368;

    typedef struct packed {
        logic band;
        logic sat;
        logic neg;
    } flags_t;

    // Configuration registers
    logic [31:0]        irr_blue_reg;
    logic [31:0]        irr_mid_reg;
    logic [31:0]        irr_green_reg;
    logic signed [23:0] coeff_reg [5];
    logic [31:0]        fb;
    logic [31:0]        fm;
    logic [31:0]        fg;

    // Flow control
    logic                  adv;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic                  pipe_valid;
    logic                  out_free;
    logic                  m_valid_reg;
    logic                  skid_valid_reg;
    logic [31:0]           m_chl_reg;
    logic [2:0]            m_status_reg;
    logic [31:0]           skid_chl_reg;
    logic [2:0]            skid_status_reg;

    // Front stages
    logic signed [64:0] pb_next, pm_next;
    flags_t             fl_next;
    logic signed [31:0] lb0_reg, lm0_reg, lg0_reg;
    logic signed [64:0] pb0_reg, pm0_reg;
    flags_t             fl_reg [5];
    logic [31:0]        nx1_reg, fx1_reg, lg1_reg;
    logic [63:0]        a2_reg, b2_reg;
    logic [70:0]        a3_reg, b3_reg;
    logic               ratio_ok4_reg;
    logic [2:0]         status_next;
    logic [2:0]         stat_reg [STAT_FIRST:STAT_LAST];
    logic [35:0]        y_nx, y_fg, y_fx, y_lg;
    logic signed [37:0] l2_6_reg;
    logic [36:0]        m_mag;
    logic [52:0]        ph7_reg;
    logic [47:0]        pl7_reg;
    logic               neg7_reg;
    logic [53:0]        sum8;
    logic [34:0]        ma8_reg;
    logic               uneg8_reg;

    // Horner stages
    logic signed [49:0] p_in       [HORNER_STEPS];
    logic [34:0]        ma_in      [HORNER_STEPS];
    logic               un_in      [HORNER_STEPS];
    logic [48:0]        mb         [HORNER_STEPS];
    logic [55:0]        pph_next   [HORNER_STEPS];
    logic [62:0]        ppl_next   [HORNER_STEPS];
    logic [56:0]        r_sum      [HORNER_STEPS];
    logic signed [57:0] prod_next  [HORNER_STEPS];
    logic signed [58:0] q_sum      [HORNER_STEPS];
    logic signed [49:0] p_next     [HORNER_STEPS];
    logic [55:0]        pph_reg    [HORNER_STEPS];
    logic [62:0]        ppl_reg    [HORNER_STEPS];
    logic               sgn_a_reg  [HORNER_STEPS];
    logic [34:0]        ma_a_reg   [HORNER_STEPS];
    logic               un_a_reg   [HORNER_STEPS];
    logic signed [57:0] prod_reg   [HORNER_STEPS];
    logic [34:0]        ma_b_reg   [HORNER_STEPS];
    logic               un_b_reg   [HORNER_STEPS];
    logic signed [49:0] p_reg      [HORNER_STEPS];
    logic [34:0]        ma_c_reg   [HORNER_STEPS];
    logic               un_c_reg   [HORNER_STEPS];

    // Exponent front
    logic signed [49:0] p_fin;
    logic [49:0]        p_abs;
    logic               sat21_reg, zero21_reg, pneg21_reg;
    logic [62:0]        prod21_reg;
    logic signed [37:0] v_val;
    logic signed [37:0] w_val;
    logic [29:0]        f22_reg;
    ocbr_side_t         side22_reg;
    ocbr_side_t         side_next;
    logic [31:0]        mm_fin;
    ocbr_side_t         side_fin;
    logic [32:0]        shifted;
    logic [31:0]        chl_fin;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irr_blue_reg  <= 32'd65536;
            irr_mid_reg   <= 32'd65536;
            irr_green_reg <= 32'd65536;
            coeff_reg[0]  <= 24'sd233623;
            coeff_reg[1]  <= -24'sd2588200;
            coeff_reg[2]  <= 24'sd1663776;
            coeff_reg[3]  <= -24'sd448266;
            coeff_reg[4]  <= -24'sd814534;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IRR_BLUE:    irr_blue_reg  <= cfg_data;
                REG_IRR_MID:     irr_mid_reg   <= cfg_data;
                REG_IRR_GREEN:   irr_green_reg <= cfg_data;
                REG_COEFF_ZERO:  coeff_reg[0]  <= cfg_data[23:0];
                REG_COEFF_ONE:   coeff_reg[1]  <= cfg_data[23:0];
                REG_COEFF_TWO:   coeff_reg[2]  <= cfg_data[23:0];
                REG_COEFF_THREE: coeff_reg[3]  <= cfg_data[23:0];
                REG_COEFF_FOUR:  coeff_reg[4]  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Treat a zero irradiance as one
    assign fb = (irr_blue_reg  == 32'd0) ? 32'd1 : irr_blue_reg;
    assign fm = (irr_mid_reg   == 32'd0) ? 32'd1 : irr_mid_reg;
    assign fg = (irr_green_reg == 32'd0) ? 32'd1 : irr_green_reg;

    // Advance the whole pipeline unless the skid word is occupied
    assign adv        = !skid_valid_reg;
    assign s_ready    = adv;
    assign pipe_valid = v_reg[PIPE_DEPTH-1] && adv;
    assign out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Stage 0: cross products of radiance and irradiance, band flags
    assign pb_next      = s_radiance_blue * $signed({1'b0, fm});
    assign pm_next      = s_radiance_mid * $signed({1'b0, fb});
    assign fl_next.band = !(s_radiance_green > 32'sd0 && s_radiance_mid > 32'sd0);
    assign fl_next.sat  = (s_radiance_mid > RAD_LIMIT) || (s_radiance_green > RAD_LIMIT);
    assign fl_next.neg  = s_radiance_green[31] || (s_radiance_blue[31] && s_radiance_mid[31]);

    // Stage 5: combine the flags into a status
    always_comb begin
        status_next = fl_reg[4].band ? STATUS_NOT_POSITIVE :
                      (ratio_ok4_reg ? STATUS_VALID : STATUS_RATIO_LOW);
        if (fl_reg[4].sat) begin
            status_next = STATUS_SATURATED;
        end
        if (fl_reg[4].neg) begin
            status_next = STATUS_NEGATIVE;
        end
    end

    // Stages 0 to 8: ratio test, band logs, scale to log10
    assign m_mag = l2_6_reg[37] ? 37'(-l2_6_reg) : 37'(l2_6_reg);
    assign sum8  = 54'(ph7_reg) + 54'(pl7_reg >> 16);

    always_ff @(posedge aclk) begin
        if (adv) begin
            lb0_reg   <= s_radiance_blue;
            lm0_reg   <= s_radiance_mid;
            lg0_reg   <= s_radiance_green;
            pb0_reg   <= pb_next;
            pm0_reg   <= pm_next;
            fl_reg[0] <= fl_next;
            for (int k = 1; k < 5; k++) begin
                fl_reg[k] <= fl_reg[k-1];
            end
            nx1_reg       <= (pb0_reg > pm0_reg) ? lb0_reg : lm0_reg;
            fx1_reg       <= (pb0_reg > pm0_reg) ? fb : fm;
            lg1_reg       <= lg0_reg;
            a2_reg        <= 64'(nx1_reg) * 64'(fg);
            b2_reg        <= 64'(fx1_reg) * 64'(lg1_reg);
            a3_reg        <= (71'(a2_reg) << 6) + (71'(a2_reg) << 5) + (71'(a2_reg) << 2);
            b3_reg        <= (71'(b2_reg) << 4) + (71'(b2_reg) << 2) + 71'(b2_reg);
            ratio_ok4_reg <= a3_reg > b3_reg;
            stat_reg[STAT_FIRST] <= status_next;
            for (int k = STAT_FIRST + 1; k <= STAT_LAST; k++) begin
                stat_reg[k] <= stat_reg[k-1];
            end
            l2_6_reg  <= $signed(38'(y_nx) + 38'(y_fg) - 38'(y_fx) - 38'(y_lg));
            ph7_reg   <= 53'(m_mag[36:16]) * 53'(LOG10_OF_2_Q32);
            pl7_reg   <= 48'(m_mag[15:0]) * 48'(LOG10_OF_2_Q32);
            neg7_reg  <= l2_6_reg[37];
            ma8_reg   <= 35'(sum8 >> 18);
            uneg8_reg <= neg7_reg;
        end
    end

    // Stages 2 to 5: log2 of each term of the ratio
    ocbr_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_nx (
        .aclk(aclk), .adv(adv), .x(nx1_reg), .y(y_nx)
    );
    ocbr_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_fg (
        .aclk(aclk), .adv(adv), .x(fg), .y(y_fg)
    );
    ocbr_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_fx (
        .aclk(aclk), .adv(adv), .x(fx1_reg), .y(y_fx)
    );
    ocbr_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_lg (
        .aclk(aclk), .adv(adv), .x(lg1_reg), .y(y_lg)
    );

    // Stages 9 to 20: Horner steps, partial products, sign, add and clamp
    for (genvar s = 0; s < HORNER_STEPS; s++) begin : g_horner
        if (s == 0) begin : g_first
            assign p_in[s]  = 50'($signed({coeff_reg[4], 8'd0}));
            assign ma_in[s] = ma8_reg;
            assign un_in[s] = uneg8_reg;
        end else begin : g_next
            assign p_in[s]  = p_reg[s-1];
            assign ma_in[s] = ma_c_reg[s-1];
            assign un_in[s] = un_c_reg[s-1];
        end
        assign mb[s]        = p_in[s][49] ? 49'(-p_in[s]) : 49'(p_in[s]);
        assign pph_next[s]  = 56'(ma_in[s]) * 56'(mb[s][48:28]);
        assign ppl_next[s]  = 63'(ma_in[s]) * 63'(mb[s][27:0]);
        assign r_sum[s]     = 57'(pph_reg[s]) + 57'(ppl_reg[s] >> 28);
        assign prod_next[s] = sgn_a_reg[s] ? -$signed({1'b0, r_sum[s]})
                                           : $signed({1'b0, r_sum[s]});
        assign q_sum[s]     = 59'(prod_reg[s]) + 59'($signed({coeff_reg[3-s], 8'd0}));
        assign p_next[s]    = (q_sum[s] > HORNER_LIMIT)  ? 50'(HORNER_LIMIT)  :
                              (q_sum[s] < -HORNER_LIMIT) ? 50'(-HORNER_LIMIT) :
                              50'(q_sum[s]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < HORNER_STEPS; s++) begin
                pph_reg[s]   <= pph_next[s];
                ppl_reg[s]   <= ppl_next[s];
                sgn_a_reg[s] <= un_in[s] ^ p_in[s][49];
                ma_a_reg[s]  <= ma_in[s];
                un_a_reg[s]  <= un_in[s];
                prod_reg[s]  <= prod_next[s];
                ma_b_reg[s]  <= ma_a_reg[s];
                un_b_reg[s]  <= un_a_reg[s];
                p_reg[s]     <= p_next[s];
                ma_c_reg[s]  <= ma_b_reg[s];
                un_c_reg[s]  <= un_b_reg[s];
            end
        end
    end

    // Stages 21 and 22: range checks, scale to log2, split the exponent
    assign p_fin = p_reg[HORNER_STEPS-1];
    assign p_abs = p_fin[49] ? 50'(-p_fin) : 50'(p_fin);
    assign v_val = pneg21_reg ? -$signed({3'b0, prod21_reg[62:28]})
                              : $signed({3'b0, prod21_reg[62:28]});
    assign w_val = v_val + W_OFFSET;

    assign side_next.n          = w_val[34:30];
    assign side_next.force_sat  = sat21_reg || (!zero21_reg && w_val >= W_TOP);
    assign side_next.force_zero = zero21_reg || (!sat21_reg && w_val < 38'sd0);
    assign side_next.status     = stat_reg[STAT_LAST];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sat21_reg  <= p_fin >= P_SAT_LIMIT;
            zero21_reg <= p_fin <= P_ZERO_LIMIT;
            pneg21_reg <= p_fin[49];
            prod21_reg <= 63'(p_abs[30:0]) * 63'(LOG2_OF_10_Q30);
            f22_reg    <= w_val[29:0];
            side22_reg <= side_next;
        end
    end

    // Stages 23 to 52: fractional power of two
    ocbr_exp2 u_exp2 (
        .aclk     (aclk),
        .adv      (adv),
        .f_in     (f22_reg),
        .side_in  (side22_reg),
        .mm_out   (mm_fin),
        .side_out (side_fin)
    );

    // Apply the integer exponent and the forced results
    assign shifted = {mm_fin, 1'b0} >> (5'd31 - side_fin.n);
    assign chl_fin = (side_fin.status != STATUS_VALID) ? 32'd0 :
                     side_fin.force_sat  ? 32'hFFFF_FFFF :
                     side_fin.force_zero ? 32'd0 : shifted[31:0];

    // Output word and skid word control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= pipe_valid;
            end
        end else if (pipe_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output word and skid word payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_chl_reg    <= skid_chl_reg;
                m_status_reg <= skid_status_reg;
            end else begin
                m_chl_reg    <= chl_fin;
                m_status_reg <= side_fin.status;
            end
        end else if (pipe_valid) begin
            skid_chl_reg    <= chl_fin;
            skid_status_reg <= side_fin.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_chlorophyll = m_chl_reg;
    assign m_status      = m_status_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held without an output word");

    a_bad_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_VALID) |-> m_chlorophyll == 32'd0)
        else $error("chlorophyll not zero on a bad status");

    a_skid_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_valid && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result word lost while output stalled");
`endif

endmodule

/* dv/tb_ocean_chlorophyll_band_ratio.sv */
module tb_ocean_chlorophyll_band_ratio;
    import ocbr_pkg::*;

    localparam int unsigned LOG_N   = DEF_LOG_TABLE_ENTRIES;
    localparam int unsigned LATENCY = FRONT_STAGES + ROOT_STEPS + 1;
    localparam longint      ONE_Q30 = 64'sd1 << 30;

    typedef struct {
        logic signed [31:0] blue;
        logic signed [31:0] mid;
        logic signed [31:0] green;
    } pixel_t;

    typedef struct {
        logic [31:0] chl;
        logic [2:0]  status;
    } chl_result_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_radiance_blue;
    logic signed [31:0] s_radiance_mid;
    logic signed [31:0] s_radiance_green;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_chlorophyll;
    logic [2:0]         m_status;

    // Shadow of the block's registers and derived tables
    logic [31:0] irr_blue, irr_mid, irr_green;
    longint      poly_coeff[5];
    logic [31:0] log_frac[LOG_N + 1];
    logic [31:0] root_frac[30];

    pixel_t      pixel_q[$];
    chl_result_t chl_q[$];
    int          error_cnt;
    int          rx_cnt;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          hold_done;
    bit          quiet;

    ocean_chlorophyll_band_ratio i_dut (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n, r, b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void build_tables();
        logic [63:0] z, acc, r;
        for (int i = 0; i < LOG_N; i++) begin
            z   = ((64'(LOG_N) + 64'(i)) << 30) / 64'(LOG_N);
            acc = '0;
            for (int k = 29; k >= 0; k--) begin
                z = (z * z) >> 30;
                if (z >= (64'd1 << 31)) begin
                    z = z >> 1;
                    acc[k] = 1'b1;
                end
            end
            log_frac[i] = acc[31:0];
        end
        log_frac[LOG_N] = 32'h4000_0000;
        r = 64'd1 << 31;
        for (int k = 0; k < 30; k++) begin
            r = int_sqrt(r << 30);
            root_frac[k] = r[31:0];
        end
    endfunction

    // log2 of a positive word, Q.30, interpolated from the table
    function automatic longint log2_fix(input logic [31:0] x);
        int          e;
        logic [63:0] f, pos, idx, w, lo, hi;
        e = 31;
        while (e > 0 && !x[e]) e--;
        f   = ({32'd0, x} << (32 - e)) & 64'hFFFF_FFFF;
        pos = f * 64'(LOG_N);
        idx = pos >> 32;
        w   = pos & 64'hFFFF_FFFF;
        lo  = log_frac[idx];
        hi  = log_frac[idx + 1];
        return longint'(e) * ONE_Q30 + longint'(lo + (((hi - lo) * w) >> 32));
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint mul_q28(input longint a, input longint b);
        logic [63:0] ma, mb, r;
        ma = mag(a);
        mb = mag(b);
        r  = ma * (mb >> 28) + ((ma * (mb & 64'h0FFF_FFFF)) >> 28);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Chlorophyll from log2 of the band ratio
    function automatic logic [31:0] chl_from_log(input longint l2);
        logic [63:0] m, um, vm, mm, f, wu;
        longint      u, p, v, w, lim;
        int          n;
        lim = 64'sd1 << 48;
        m  = mag(l2);
        um = (((m >> 16) * 64'(LOG10_OF_2_Q32))
              + (((m & 64'hFFFF) * 64'(LOG10_OF_2_Q32)) >> 16)) >> 18;
        u  = l2 < 0 ? -longint'(um) : longint'(um);
        p  = poly_coeff[4] * 256;
        for (int k = 3; k >= 0; k--) begin
            p = mul_q28(u, p) + poly_coeff[k] * 256;
            if (p > lim) p = lim;
            if (p < -lim) p = -lim;
        end
        if (p >= (64'sd4 << 28)) return 32'hFFFF_FFFF;
        if (p <= -(64'sd8 << 28)) return 32'd0;
        vm = (mag(p) * 64'(LOG2_OF_10_Q30)) >> 28;
        v  = p < 0 ? -longint'(vm) : longint'(vm);
        w  = v + 22 * ONE_Q30;
        if (w < 0) return 32'd0;
        if (w >= 32 * ONE_Q30) return 32'hFFFF_FFFF;
        wu = 64'(w);
        n  = int'(wu >> 30);
        f  = wu & 64'h3FFF_FFFF;
        mm = 64'(ONE_Q30);
        for (int j = 0; j < 30; j++)
            if (f[29 - j]) mm = (mm * 64'(root_frac[j])) >> 30;
        mm = n >= 30 ? mm << (n - 30) : mm >> (30 - n);
        return mm[31:0];
    endfunction

    function automatic chl_result_t predict_chl(input pixel_t px);
        chl_result_t  res;
        longint       lb, lm, lg, fb, fm, fg, nx, fx, l2;
        logic [127:0] a, b;
        lb = px.blue;
        lm = px.mid;
        lg = px.green;
        // a zero irradiance acts as one LSB
        fb = irr_blue  == 0 ? 1 : longint'({32'd0, irr_blue});
        fm = irr_mid   == 0 ? 1 : longint'({32'd0, irr_mid});
        fg = irr_green == 0 ? 1 : longint'({32'd0, irr_green});
        res.chl = '0;
        if (!(lg > 0 && lm > 0)) begin
            res.status = STATUS_NOT_POSITIVE;
        end else begin
            nx = lm;
            fx = fm;
            if (lb * fm > lm * fb) begin
                nx = lb;
                fx = fb;
            end
            a = 128'(64'(nx) * 64'(fg));
            b = 128'(64'(fx) * 64'(lg));
            if (a * 128'd100 > b * 128'd21) begin
                l2 = log2_fix(nx[31:0]) + log2_fix(fg[31:0])
                   - log2_fix(fx[31:0]) - log2_fix(lg[31:0]);
                res.chl    = chl_from_log(l2);
                res.status = STATUS_VALID;
            end else begin
                res.status = STATUS_RATIO_LOW;
            end
        end
        if (lm > longint'(RAD_LIMIT) || lg > longint'(RAD_LIMIT))
            res.status = STATUS_SATURATED;
        if (lg < 0 || (lb < 0 && lm < 0))
            res.status = STATUS_NEGATIVE;
        if (res.status != STATUS_VALID)
            res.chl = '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (word %0d)", what, got, want, rx_cnt);
        error_cnt++;
    endtask

    // Write one register and the shadow copy
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_IRR_BLUE:  irr_blue  = val;
            REG_IRR_MID:   irr_mid   = val;
            REG_IRR_GREEN: irr_green = val;
            default:       poly_coeff[idx - REG_COEFF_ZERO] =
                               longint'($signed(val[23:0]));
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_pixel(input logic [31:0] bl, input logic [31:0] md,
                             input logic [31:0] gr);
        pixel_t px;
        px.blue  = bl;
        px.mid   = md;
        px.green = gr;
        pixel_q.push_back(px);
    endtask

    // Mostly plausible radiances, some raw noise
    task automatic add_random(input int count);
        logic [31:0] bl, md, gr;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                bl = $urandom;
                md = $urandom;
                gr = $urandom;
            end else begin
                gr = $urandom_range(1, $urandom_range(0, 1) ? 1310720 : 4000);
                md = $urandom_range(1, $urandom_range(0, 1) ? 1310720 : 4000);
                bl = $urandom_range(0, $urandom_range(0, 1) ? 1400000 : 4000);
                if ($urandom_range(0, 15) == 0) bl = -bl;
                if ($urandom_range(0, 31) == 0) md = md + 1310720;
            end
            add_pixel(bl, md, gr);
        end
    endtask

    // Hold until every word is sent and every result is back
    task automatic drain();
        while (pixel_q.size() != 0 || s_valid || chl_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                chl_q.push_back(predict_chl('{s_radiance_blue, s_radiance_mid,
                                              s_radiance_green}));
            if (!s_valid || s_ready) begin
                if (gap_left > 0 && !quiet) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_valid          <= 1'b1;
                    s_radiance_blue  <= pixel_q[0].blue;
                    s_radiance_mid   <= pixel_q[0].mid;
                    s_radiance_green <= pixel_q[0].green;
                    void'(pixel_q.pop_front());
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each word, stall at random, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_cnt    <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (chl_q.size() == 0) begin
                    report_mismatch("unexpected word", m_chlorophyll, 0);
                end else begin
                    if (m_chlorophyll !== chl_q[0].chl)
                        report_mismatch("chlorophyll", m_chlorophyll, chl_q[0].chl);
                    if (m_status !== chl_q[0].status)
                        report_mismatch("status", 32'(m_status), 32'(chl_q[0].status));
                    void'(chl_q.pop_front());
                end
                rx_cnt <= rx_cnt + 1;
            end
            if (!hold_done && rx_cnt == 250) begin
                hold_done <= 1'b1;
                hold_left <= 300;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= (rx_cnt % 11) < 6 ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        build_tables();
        error_cnt = 0;
        quiet     = 1'b0;
        irr_blue  = 32'd65536;
        irr_mid   = 32'd65536;
        irr_green = 32'd65536;
        poly_coeff[0] = 233623;
        poly_coeff[1] = -2588200;
        poly_coeff[2] = 1663776;
        poly_coeff[3] = -448266;
        poly_coeff[4] = -814534;
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_IRR_BLUE;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_radiance_blue  = '0;
        s_radiance_mid   = '0;
        s_radiance_green = '0;
        m_ready          = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, limits and status priorities
        add_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pixel(0, 0, 0);
        add_pixel(100, 100, 0);
        add_pixel(100, 0, 100);
        add_pixel(100, 21, 100);
        add_pixel(21, 21, 100);
        add_pixel(22, 10, 100);
        add_pixel(500, 500, 700);
        add_pixel(65536, 65536, 65536);
        add_pixel(1310720, 1310720, 1);
        add_pixel(1, 1310721, 1000);
        add_pixel(1, 1000, 1310721);
        add_pixel(1, 0, 1310721);
        add_pixel(-5, -5, 1000);
        add_pixel(-5, 900, 1000);
        add_pixel(50, 50, -1);
        add_pixel(1, 1, 1);
        add_pixel(300000, 20000, 65536);
        add_pixel(2, 1, 32'h7FFF_FFFF);
        add_random(150);
        drain();

        // New irradiances and coefficients
        cfg_write(REG_IRR_BLUE, $urandom_range(30000, 200000));
        cfg_write(REG_IRR_MID, $urandom_range(30000, 200000));
        cfg_write(REG_IRR_GREEN, $urandom_range(30000, 200000));
        for (int k = 0; k < 5; k++)
            cfg_write(REG_COEFF_ZERO + 3'(k), 32'($urandom_range(0, 16777215)));
        add_random(200);
        drain();

        // Register extremes, zero irradiance included
        cfg_write(REG_IRR_BLUE, 32'd1);
        cfg_write(REG_IRR_MID, 32'd0);
        cfg_write(REG_IRR_GREEN, 32'hFFFF_FFFF);
        cfg_write(REG_COEFF_ZERO, 32'h007F_FFFF);
        cfg_write(REG_COEFF_ONE, 32'hFF80_0000);
        cfg_write(REG_COEFF_TWO, 32'h007F_FFFF);
        cfg_write(REG_COEFF_THREE, 32'hFF80_0000);
        cfg_write(REG_COEFF_FOUR, 32'h007F_FFFF);
        add_pixel(32'h7FFF_FFFF, 1, 1);
        add_pixel(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_random(100);
        drain();

        cfg_write(REG_IRR_BLUE, 32'hFFFF_FFFF);
        cfg_write(REG_IRR_MID, 32'd1);
        cfg_write(REG_IRR_GREEN, 32'd1);
        cfg_write(REG_COEFF_ZERO, 32'hFF80_0000);
        cfg_write(REG_COEFF_FOUR, 32'hFF80_0000);
        add_random(50);
        drain();

        // Back to defaults, a stretch with no idling on either side
        cfg_write(REG_IRR_BLUE, 32'd65536);
        cfg_write(REG_IRR_MID, 32'd65536);
        cfg_write(REG_IRR_GREEN, 32'd65536);
        cfg_write(REG_COEFF_ZERO, 32'(233623));
        cfg_write(REG_COEFF_ONE, 32'(-2588200));
        cfg_write(REG_COEFF_TWO, 32'(1663776));
        cfg_write(REG_COEFF_THREE, 32'(-448266));
        cfg_write(REG_COEFF_FOUR, 32'(-814534));
        @(negedge aclk);
        quiet = 1'b1;
        add_random(60);
        while (pixel_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
        quiet = 1'b0;
        add_random(40);
        drain();

        if (error_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
